/* hdl/tops_pkg.sv */
// ----------------------------------------------------------------------------
// Timed output pulse scheduler package
// Shared sizes, payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tops_pkg;

  localparam int ADDRESS_COUNT = 8;
  localparam int WORD_BITS     = 32;
  localparam int QUEUE_DEPTH   = 16;

  localparam int OUT_W   = 32;
  localparam int TIME_W  = 32;
  localparam int IN_ADDR_W = 8;
  localparam int IN_BIT_W  = 6;

  localparam int ADDR_W  = (ADDRESS_COUNT > 1) ? $clog2(ADDRESS_COUNT) : 1;
  localparam int BIT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_SERVICE = 1'b1
  } action_t;

  typedef struct packed {
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    on_time;
    logic                 latched;
    logic                 level;
    logic [IN_BIT_W-1:0]  bit_index;
    logic [IN_ADDR_W-1:0] address;
  } in_data_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_req;
    logic last_entry;
  } dp_status_t;

endpackage

/* hdl/timed_output_pulse_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Timed output pulse scheduler core
// Per-address output words driven by an age-ordered queue of latched and
// timed bit commands, with a streaming input and result channel.
// ----------------------------------------------------------------------------
// Sequence: an accepted word is captured; a service word for a valid address
// with queued entries then walks all of them, one entry per cycle; the result
// is then registered onto the result channel once that channel is free.
// Flow: a new input word is taken only once the result of the last one has been
// loaded; the queue depth is 16; a stalled result holds back the one after it.
// Reset: synchronous active-low rst_n empties the queue, clears all output
// words and the link flag, and drops any pending result.
module timed_output_pulse_scheduler_core
  import tops_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,  // link_up
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // address[7:0], bit_index[13:8], level[14], latched[15],
  // on_time[47:16], now[79:48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,     // action[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata     // ok[0], word[32:1], zero[39:33]
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tops_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tops_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .status      (status),
    .out_tdata   (out_tdata)
  );

endmodule

/* hdl/tops_ctrl.sv */
// ----------------------------------------------------------------------------
// Timed output pulse scheduler controller
// Sequences capture, queue walk and result hand-off for one word at a time.
// ----------------------------------------------------------------------------
module tops_ctrl
  import tops_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = status.walk_req ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (status.last_entry) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

/* hdl/tops_dp.sv */
// ----------------------------------------------------------------------------
// Timed output pulse scheduler datapath
// Holds output words, the command queue and the link flag; walks one entry
// per cycle and closes up removed entries as it goes.
// ----------------------------------------------------------------------------
module tops_dp
  import tops_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [IN_ADDR_W:0] ADDR_LIMIT = (IN_ADDR_W + 1)'(ADDRESS_COUNT);
  localparam logic [IN_BIT_W:0]  BIT_LIMIT  = (IN_BIT_W + 1)'(WORD_BITS);
  localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]   CNT_ONE    = CNT_W'(1);

  in_data_t in_d;

  logic                link_up_r;
  logic [OUT_W-1:0]    words_r [ADDRESS_COUNT];
  logic [CNT_W-1:0]    count_r;

  logic [ADDR_W-1:0]   q_addr_r    [QUEUE_DEPTH];
  logic [BIT_W-1:0]    q_bit_r     [QUEUE_DEPTH];
  logic                q_level_r   [QUEUE_DEPTH];
  logic                q_latched_r [QUEUE_DEPTH];
  logic                q_started_r [QUEUE_DEPTH];
  logic [TIME_W-1:0]   q_start_r   [QUEUE_DEPTH];
  logic [TIME_W-1:0]   q_on_r      [QUEUE_DEPTH];

  logic                action_r;
  logic [ADDR_W-1:0]   cap_addr_r;
  logic [TIME_W-1:0]   cap_now_r;
  logic                enq_ok_r;
  logic                walk_r;
  logic [OUT_W-1:0]    w_r, w_nxt;
  logic [IDX_W-1:0]    rd_r;
  logic [CNT_W-1:0]    wr_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                addr_ok;
  logic                bit_ok;
  logic                enq_ok;
  logic [ADDR_W-1:0]   in_addr_idx;

  logic                e_match;
  logic [OUT_W-1:0]    e_mask;
  logic [TIME_W-1:0]   e_elapsed;
  logic                e_expired;
  logic                e_drop;
  logic                e_started;
  logic [TIME_W-1:0]   e_start;

  assign in_d        = in_data_t'(in_tdata);
  assign in_addr_idx = in_d.address[ADDR_W-1:0];
  assign addr_ok     = {1'b0, in_d.address} < ADDR_LIMIT;
  assign bit_ok      = {1'b0, in_d.bit_index} < BIT_LIMIT;
  assign enq_ok      = addr_ok && bit_ok && link_up_r && (count_r < CNT_FULL);

  assign status.walk_req   = (action_t'(in_tuser) == ACT_SERVICE) && addr_ok &&
                             (count_r != '0);
  assign status.last_entry = (rd_r == IDX_W'(count_r - CNT_ONE));
  assign out_tdata         = out_data_r;

  always_comb begin
    e_match   = (q_addr_r[rd_r] == cap_addr_r);
    e_mask    = OUT_W'(1) << q_bit_r[rd_r];
    e_elapsed = cap_now_r - q_start_r[rd_r];
    e_expired = e_elapsed >= q_on_r[rd_r];
    e_drop    = e_match && (q_latched_r[rd_r] || (q_started_r[rd_r] && e_expired));
    e_started = q_started_r[rd_r] || e_match;
    e_start   = (e_match && !q_started_r[rd_r]) ? cap_now_r : q_start_r[rd_r];
    w_nxt     = w_r;
    if (e_match) begin
      if (q_latched_r[rd_r]) begin
        w_nxt = q_level_r[rd_r] ? (w_r | e_mask) : (w_r & ~e_mask);
      end else if (!q_started_r[rd_r]) begin
        w_nxt = w_r | e_mask;
      end else if (e_expired) begin
        w_nxt = w_r & ~e_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_r <= 1'b0;
      count_r   <= '0;
      for (int i = 0; i < ADDRESS_COUNT; i++) begin
        words_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        link_up_r <= cfg_wr_data;
      end
      if (cmd.load && (action_t'(in_tuser) == ACT_ENQUEUE) && enq_ok) begin
        count_r <= count_r + CNT_ONE;
      end
      if (cmd.out_load && walk_r) begin
        count_r              <= wr_r;
        words_r[cap_addr_r] <= w_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r   <= in_tuser;
      cap_addr_r <= in_addr_idx;
      cap_now_r  <= in_d.now;
      enq_ok_r   <= enq_ok;
      walk_r     <= status.walk_req;
      w_r        <= addr_ok ? words_r[in_addr_idx] : '0;
      rd_r       <= '0;
      wr_r       <= '0;
      if ((action_t'(in_tuser) == ACT_ENQUEUE) && enq_ok) begin
        q_addr_r[count_r[IDX_W-1:0]]    <= in_addr_idx;
        q_bit_r[count_r[IDX_W-1:0]]     <= in_d.bit_index[BIT_W-1:0];
        q_level_r[count_r[IDX_W-1:0]]   <= in_d.level;
        q_latched_r[count_r[IDX_W-1:0]] <= in_d.latched;
        q_started_r[count_r[IDX_W-1:0]] <= 1'b0;
        q_start_r[count_r[IDX_W-1:0]]   <= '0;
        q_on_r[count_r[IDX_W-1:0]]      <= in_d.on_time;
      end
    end
    if (cmd.step) begin
      w_r  <= w_nxt;
      rd_r <= rd_r + IDX_W'(1);
      if (!e_drop) begin
        q_addr_r[wr_r[IDX_W-1:0]]    <= q_addr_r[rd_r];
        q_bit_r[wr_r[IDX_W-1:0]]     <= q_bit_r[rd_r];
        q_level_r[wr_r[IDX_W-1:0]]   <= q_level_r[rd_r];
        q_latched_r[wr_r[IDX_W-1:0]] <= q_latched_r[rd_r];
        q_started_r[wr_r[IDX_W-1:0]] <= e_started;
        q_start_r[wr_r[IDX_W-1:0]]   <= e_start;
        q_on_r[wr_r[IDX_W-1:0]]      <= q_on_r[rd_r];
        wr_r                         <= wr_r + CNT_ONE;
      end
    end
    if (cmd.out_load) begin
      if (action_t'(action_r) == ACT_ENQUEUE) begin
        out_data_r <= OUT_DATA_W'(enq_ok_r);
      end else begin
        out_data_r <= OUT_DATA_W'({w_r, (count_r != '0)});
      end
    end
  end

endmodule

/* tb/timed_output_pulse_scheduler_core_test.sv */
// ----------------------------------------------------------------------------
// Timed output pulse scheduler core testbench
// Sends enqueue and service words through the streaming ports with the link
// up and down and under several flow-control patterns. A local model of the
// output words and the age-ordered command queue predicts each result word,
// and the results are checked in order.
// ----------------------------------------------------------------------------
module timed_output_pulse_scheduler_core_test;
  import tops_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    action_t  action;
    in_data_t data;
  } sched_word_t;

  typedef struct {
    logic        ok;
    logic [31:0] word;
  } reply_t;

  typedef struct {
    logic [7:0]  addr;
    logic [5:0]  bit_index;
    logic        level;
    logic        latched;
    logic        started;
    logic [31:0] start_time;
    logic [31:0] on_time;
  } pend_cmd_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  sched_word_t words_to_send[$];
  reply_t      replies_due[$];
  pend_cmd_t   cmd_queue[$];
  logic [31:0] port_words[ADDRESS_COUNT];
  logic        link_up_model = 1'b0;
  logic        in_taken = 1'b0;
  logic [31:0] time_base;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          words_issued = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          cycles = 0;

  timed_output_pulse_scheduler_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic reply_t scheduler_reply(sched_word_t w);
    reply_t      r;
    pend_cmd_t   c;
    logic [63:0] acc;
    logic [63:0] mask;
    logic [31:0] elapsed;
    int          i;
    r.ok = 1'b0;
    r.word = '0;
    if (w.action == ACT_ENQUEUE) begin
      if (w.data.address < ADDRESS_COUNT && w.data.bit_index < WORD_BITS &&
          link_up_model && cmd_queue.size() < QUEUE_DEPTH) begin
        c.addr = w.data.address;
        c.bit_index = w.data.bit_index;
        c.level = w.data.level;
        c.latched = w.data.latched;
        c.started = 1'b0;
        c.start_time = '0;
        c.on_time = w.data.on_time;
        cmd_queue.insert(cmd_queue.size(), c);
        r.ok = 1'b1;
      end
    end else if (w.data.address >= ADDRESS_COUNT) begin
      r.ok = (cmd_queue.size() != 0);
    end else if (cmd_queue.size() == 0) begin
      r.word = port_words[w.data.address];
    end else begin
      acc = {32'd0, port_words[w.data.address]};
      i = 0;
      while (i < cmd_queue.size()) begin
        c = cmd_queue[i];
        mask = 64'd1 << c.bit_index;
        elapsed = w.data.now - c.start_time;
        if (c.addr != w.data.address) begin
          i++;
        end else if (c.latched) begin
          acc = c.level ? (acc | mask) : (acc & ~mask);
          cmd_queue.delete(i);
        end else if (!c.started) begin
          acc = acc | mask;
          cmd_queue[i].started = 1'b1;
          cmd_queue[i].start_time = w.data.now;
          i++;
        end else if (elapsed >= c.on_time) begin
          acc = acc & ~mask;
          cmd_queue.delete(i);
        end else begin
          i++;
        end
      end
      port_words[w.data.address] = acc[31:0];
      r.ok = 1'b1;
      r.word = acc[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 40) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
    errors++;
  endtask

  task automatic send(input action_t act, input logic [7:0] addr, input logic [5:0] bidx,
                      input logic lvl, input logic lat, input logic [31:0] on_t,
                      input logic [31:0] t_now);
    sched_word_t w;
    w.action = act;
    w.data.address = addr;
    w.data.bit_index = bidx;
    w.data.level = lvl;
    w.data.latched = lat;
    w.data.on_time = on_t;
    w.data.now = t_now;
    words_to_send.insert(words_to_send.size(), w);
    words_issued++;
  endtask

  task automatic set_link(input logic up);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= up;
    link_up_model = up;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_all_answered();
    while (results_seen < words_issued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_random_words(input int n);
    int          sel;
    logic [31:0] on_t;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      time_base += $urandom_range(0, 24);
      on_t = ($urandom_range(9) < 8) ? $urandom_range(0, 60) : $urandom;
      if (sel < 42) begin
        send(ACT_ENQUEUE, 8'($urandom_range(ADDRESS_COUNT - 1)),
             6'($urandom_range(WORD_BITS - 1)),
             1'($urandom_range(1)), 1'($urandom_range(1)), on_t, time_base);
      end else if (sel < 90) begin
        send(ACT_SERVICE, 8'($urandom_range(ADDRESS_COUNT - 1)), 6'($urandom_range(63)),
             1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, time_base);
      end else begin
        send(action_t'($urandom_range(1)), 8'($urandom_range(255)), 6'($urandom_range(63)),
             1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom);
      end
    end
  endtask

  always @(negedge clk) begin : driver
    sched_word_t nxt;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (!(in_tvalid && !in_taken)) begin
      if (rst_n && words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = words_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.action;
        in_tdata <= nxt.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    sched_word_t seen;
    reply_t      due;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[timed_output_pulse_scheduler_core] ERROR");
      $finish;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (rst_n && in_tvalid && in_tready) begin
        seen.action = action_t'(in_tuser);
        seen.data = in_tdata;
        replies_due.insert(replies_due.size(), scheduler_reply(seen));
      end
      if (rst_n && out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_tdata));
        end else begin
          due = replies_due.pop_front();
          results_seen++;
          if (out_tdata[0] !== due.ok) begin
            report_mismatch($sformatf("ok %b, expected %b", out_tdata[0], due.ok));
          end
          if (out_tdata[32:1] !== due.word) begin
            report_mismatch($sformatf("word %h, expected %h", out_tdata[32:1], due.word));
          end
        end
      end
    end
  end

  initial begin
    foreach (port_words[i]) port_words[i] = '0;
    cmd_queue.delete();
    time_base = 32'hFFFF_F000;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send(ACT_ENQUEUE, 0, 0, 1, 1, 0, 0);
    send(ACT_SERVICE, 0, 0, 0, 0, 0, 0);
    send(ACT_SERVICE, 255, 63, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_all_answered();
    set_link(1'b1);

    send(ACT_ENQUEUE, 0, 0, 1, 1, 0, 0);
    send(ACT_ENQUEUE, 7, 31, 1, 1, 0, 0);
    send(ACT_ENQUEUE, 8, 0, 1, 1, 0, 0);
    send(ACT_ENQUEUE, 255, 0, 1, 1, 0, 0);
    send(ACT_ENQUEUE, 1, 32, 1, 1, 0, 0);
    send(ACT_ENQUEUE, 1, 63, 1, 1, 0, 0);
    send(ACT_ENQUEUE, 0, 5, 0, 0, 10, 0);
    send(ACT_SERVICE, 255, 0, 0, 0, 0, 100);
    send(ACT_SERVICE, 0, 0, 0, 0, 0, 100);
    send(ACT_SERVICE, 0, 0, 0, 0, 0, 105);
    send(ACT_SERVICE, 0, 0, 0, 0, 0, 110);
    send(ACT_SERVICE, 7, 0, 0, 0, 0, 0);
    send(ACT_ENQUEUE, 7, 31, 0, 1, 0, 0);
    send(ACT_SERVICE, 7, 0, 0, 0, 0, 0);
    send(ACT_ENQUEUE, 1, 3, 1, 0, 32'h20, 0);
    send(ACT_SERVICE, 1, 0, 0, 0, 0, 32'hFFFF_FFF0);
    send(ACT_SERVICE, 1, 0, 0, 0, 0, 32'h10);
    send(ACT_ENQUEUE, 2, 1, 0, 0, 32'hFFFF_FFFF, 0);
    send(ACT_SERVICE, 2, 0, 0, 0, 0, 0);
    send(ACT_SERVICE, 2, 0, 0, 0, 0, 32'hFFFF_FFFE);
    queue_random_words(270);
    wait_all_answered();

    set_link(1'b0);
    send_idle_pct = 81;
    queue_random_words(200);
    wait_all_answered();

    set_link(1'b1);
    send_idle_pct = 0;
    stall_pct = 81;
    queue_random_words(300);
    wait_all_answered();

    set_link(1'b1);
    send_idle_pct = 36;
    stall_pct = 36;
    queue_random_words(280);
    wait_all_answered();

    repeat (40) @(negedge clk);
    if (replies_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", replies_due.size()));
    end
    if (errors == 0) begin
      $display("[timed_output_pulse_scheduler_core] OK");
    end else begin
      $display("[timed_output_pulse_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/tops_pkg.sv
hdl/tops_ctrl.sv
hdl/tops_dp.sv
hdl/timed_output_pulse_scheduler_core.sv
tb/timed_output_pulse_scheduler_core_test.sv
